### rtl/core/halcc_pkg.sv
package halcc_pkg;

   localparam int TIMER_WIDTH = 16;
   localparam int DIGIT_WIDTH = 4;
   localparam int CSR_DATA_WIDTH = 16;
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int REQ_DATA_WIDTH = 8;
   localparam int RSP_DATA_WIDTH = 16;

   localparam logic [TIMER_WIDTH-1:0] LIGHT_HOLD_RESET = TIMER_WIDTH'(25);
   localparam logic [TIMER_WIDTH-1:0] PRESS_GAP_RESET = TIMER_WIDTH'(5);
   localparam logic [DIGIT_WIDTH-1:0] SECRET_FIRST_RESET = 4'd7;
   localparam logic [DIGIT_WIDTH-1:0] SECRET_SECOND_RESET = 4'd5;
   localparam logic [DIGIT_WIDTH-1:0] SECRET_THIRD_RESET = 4'd9;
   localparam logic [DIGIT_WIDTH-1:0] DIGIT_MAX = 4'd9;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_LIGHT_HOLD = 3'd0,
      CSR_PRESS_GAP = 3'd1,
      CSR_SECRET_FIRST = 3'd2,
      CSR_SECRET_SECOND = 3'd3,
      CSR_SECRET_THIRD = 3'd4
   } csr_index_type;

   typedef enum logic [1:0] {
      CODE_EVENT_NONE = 2'd0,
      CODE_EVENT_WRONG = 2'd1,
      CODE_EVENT_RIGHT = 2'd2
   } code_event_type;

   typedef enum logic [1:0] {
      POS_FIRST = 2'd0,
      POS_SECOND = 2'd1,
      POS_THIRD = 2'd2
   } digit_pos_type;

   // pending flag bits
   localparam int PF_CODE = 0;
   localparam int PF_LIGHT = 1;
   localparam int PF_PRES_L = 2;
   localparam int PF_PRES_A = 3;

   // first member lands in the highest bits
   typedef struct packed {
      code_event_type code_event;
      logic [DIGIT_WIDTH-1:0] digit_value;
      logic [1:0] digit_position;
      logic siren_on;
      logic armed;
      logic light_on;
   } rsp_type;

endpackage

### rtl/core/home_alarm_light_code_controller.sv
// channel | dir | tdata fields (lsb first)                                   | other
// req     | in  | code_press, light_press, presence_seen                     | -
// rsp     | out | light_on, armed, siren_on, digit_position[1:0],            | -
//         |     | digit_value[3:0], code_event[1:0]                           |
// csr     | in  | csr_we, csr_index (0 hold, 1 gap, 2..4 secret), csr_wdata   | -
//
// one tick per cycle while req_tready is high: the whole state update sits between the state
// registers and the result register, so a tick beat is taken every cycle unless rsp backs up
// each result is registered in the output entry, or in the skid entry while that one is held
// two result entries (output plus skid) let a tick in while a result waits;
// req_tready drops only when both are full
// synchronous active-high reset restores the register defaults, clears all tick state and both result valid flags
module home_alarm_light_code_controller import halcc_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   // code_press, light_press, presence_seen, zero fill
   input  logic [REQ_DATA_WIDTH-1:0]  req_tdata,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   // light_on, armed, siren_on, digit_position, digit_value, code_event, zero fill
   output logic [RSP_DATA_WIDTH-1:0]  rsp_tdata,
   input  logic                       csr_we,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_wdata
);

   logic [TIMER_WIDTH-1:0] hold_ff, gap_ff;
   logic [DIGIT_WIDTH-1:0] secret0_ff, secret1_ff, secret2_ff;

   logic                   light_ff, light_in;
   logic [TIMER_WIDTH-1:0] light_cnt_ff, light_cnt_in;
   logic                   armed_ff, armed_in;
   logic                   siren_ff, siren_in;
   logic [3:0]             pend_ff, pend_in;
   logic                   pulse_ff, pulse_in;
   logic [DIGIT_WIDTH-1:0] digit0_ff, digit0_in;
   logic [DIGIT_WIDTH-1:0] digit1_ff, digit1_in;
   logic [DIGIT_WIDTH-1:0] digit2_ff, digit2_in;
   logic [1:0]             pos_ff, pos_in;
   logic [TIMER_WIDTH-1:0] press_cnt_ff, press_cnt_in;
   logic                   press_act_ff, press_act_in;

   rsp_type out_ff, skid_ff, result;
   logic    out_valid_ff, skid_valid_ff;

   logic                   accept, pop, match;
   logic [1:0]             pos_cur;
   logic [DIGIT_WIDTH-1:0] digit_cur, digit_inc, digit_out;
   code_event_type         event_w;

   assign req_tready = !skid_valid_ff;
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = out_valid_ff;
   assign pop        = out_valid_ff && rsp_tready;
   assign rsp_tdata  = {{(RSP_DATA_WIDTH - $bits(rsp_type)){1'b0}}, out_ff};

   always_comb begin
      pos_cur = (pos_ff == 2'd3) ? POS_THIRD : pos_ff;
      case (pos_cur)
         POS_FIRST:  digit_cur = digit0_ff;
         POS_SECOND: digit_cur = digit1_ff;
         default:    digit_cur = digit2_ff;
      endcase
      digit_inc = (digit_cur >= DIGIT_MAX) ? '0 : digit_cur + 4'd1;
      match = (digit0_ff == secret0_ff) && (digit1_ff == secret1_ff)
              && (digit2_ff == secret2_ff);
   end

   always_comb begin
      pend_in      = pend_ff;
      light_in     = light_ff;
      light_cnt_in = light_cnt_ff;
      armed_in     = armed_ff;
      siren_in     = siren_ff;
      pulse_in     = pulse_ff;
      digit0_in    = digit0_ff;
      digit1_in    = digit1_ff;
      digit2_in    = digit2_ff;
      pos_in       = pos_ff;
      press_cnt_in = press_cnt_ff;
      press_act_in = press_act_ff;
      event_w      = CODE_EVENT_NONE;

      // latch events
      if (req_tdata[0]) pend_in[PF_CODE] = 1'b1;
      if (req_tdata[1]) pend_in[PF_LIGHT] = 1'b1;
      if (req_tdata[2]) begin
         pend_in[PF_PRES_L] = 1'b1;
         pend_in[PF_PRES_A] = 1'b1;
      end

      // light
      if (!light_ff) begin
         if (pend_in[PF_LIGHT] || pend_in[PF_PRES_L]) begin
            light_in = 1'b1;
            pend_in[PF_LIGHT] = 1'b0;
            pend_in[PF_PRES_L] = 1'b0;
            light_cnt_in = hold_ff;
         end
      end else if (pend_in[PF_LIGHT]) begin
         light_in = 1'b0;
         pend_in[PF_LIGHT] = 1'b0;
      end else if (pend_in[PF_PRES_L]) begin
         pend_in[PF_LIGHT] = 1'b0;
         pend_in[PF_PRES_L] = 1'b0;
         light_cnt_in = hold_ff;
      end else if (light_cnt_ff <= TIMER_WIDTH'(1)) begin
         light_cnt_in = '0;
         light_in = 1'b0;
      end else begin
         light_cnt_in = light_cnt_ff - TIMER_WIDTH'(1);
      end

      // alarm
      if (!armed_ff) begin
         if (pulse_ff) begin
            armed_in = 1'b1;
            pend_in[PF_PRES_A] = 1'b0;
            pulse_in = 1'b0;
         end
      end else if (pend_in[PF_PRES_A]) begin
         siren_in = 1'b1;
         pend_in[PF_PRES_A] = 1'b0;
      end else if (pulse_ff) begin
         armed_in = 1'b0;
         siren_in = 1'b0;
         pend_in[PF_PRES_A] = 1'b0;
         pulse_in = 1'b0;
      end

      // code entry
      if (pend_in[PF_CODE]) begin
         case (pos_cur)
            POS_FIRST:  digit0_in = digit_inc;
            POS_SECOND: digit1_in = digit_inc;
            default:    digit2_in = digit_inc;
         endcase
         pend_in[PF_CODE] = 1'b0;
         press_cnt_in = gap_ff;
         pulse_in = 1'b0;
         press_act_in = 1'b1;
      end else if (press_act_ff) begin
         if (press_cnt_ff > TIMER_WIDTH'(1)) begin
            press_cnt_in = press_cnt_ff - TIMER_WIDTH'(1);
         end else begin
            press_cnt_in = '0;
            press_act_in = 1'b0;
            if (pos_cur != POS_THIRD) begin
               pos_in = pos_cur + 2'd1;
               pulse_in = 1'b0;
            end else begin
               digit0_in = '0;
               digit1_in = '0;
               digit2_in = '0;
               pos_in = POS_FIRST;
               pulse_in = match;
               event_w = match ? CODE_EVENT_RIGHT : CODE_EVENT_WRONG;
            end
         end
      end

      case (pos_in)
         POS_FIRST:  digit_out = digit0_in;
         POS_SECOND: digit_out = digit1_in;
         default:    digit_out = digit2_in;
      endcase

      result.light_on       = light_in;
      result.armed          = armed_in;
      result.siren_on       = siren_in;
      result.digit_position = pos_in;
      result.digit_value    = digit_out;
      result.code_event     = event_w;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_ff    <= LIGHT_HOLD_RESET;
         gap_ff     <= PRESS_GAP_RESET;
         secret0_ff <= SECRET_FIRST_RESET;
         secret1_ff <= SECRET_SECOND_RESET;
         secret2_ff <= SECRET_THIRD_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_LIGHT_HOLD:    hold_ff <= csr_wdata[TIMER_WIDTH-1:0];
            CSR_PRESS_GAP:     gap_ff <= csr_wdata[TIMER_WIDTH-1:0];
            CSR_SECRET_FIRST:  secret0_ff <= csr_wdata[DIGIT_WIDTH-1:0];
            CSR_SECRET_SECOND: secret1_ff <= csr_wdata[DIGIT_WIDTH-1:0];
            CSR_SECRET_THIRD:  secret2_ff <= csr_wdata[DIGIT_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         light_ff     <= 1'b0;
         light_cnt_ff <= '0;
         armed_ff     <= 1'b0;
         siren_ff     <= 1'b0;
         pend_ff      <= '0;
         pulse_ff     <= 1'b0;
         digit0_ff    <= '0;
         digit1_ff    <= '0;
         digit2_ff    <= '0;
         pos_ff       <= POS_FIRST;
         press_cnt_ff <= '0;
         press_act_ff <= 1'b0;
      end else if (accept) begin
         light_ff     <= light_in;
         light_cnt_ff <= light_cnt_in;
         armed_ff     <= armed_in;
         siren_ff     <= siren_in;
         pend_ff      <= pend_in;
         pulse_ff     <= pulse_in;
         digit0_ff    <= digit0_in;
         digit1_ff    <= digit1_in;
         digit2_ff    <= digit2_in;
         pos_ff       <= pos_in;
         press_cnt_ff <= press_cnt_in;
         press_act_ff <= press_act_in;
      end
   end

   // output register plus skid entry
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (!out_valid_ff || pop) begin
         if (skid_valid_ff) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            out_valid_ff <= accept;
         end
      end else if (accept) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!out_valid_ff || pop) begin
         out_ff <= skid_valid_ff ? skid_ff : result;
      end else if (accept) begin
         skid_ff <= result;
      end
   end

   a_siren_needs_armed: assert property (@(posedge clock) disable iff (reset)
      siren_ff |-> armed_ff) else $error("siren on while disarmed");

   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff) else $error("skid entry without output entry");

   a_digits_in_range: assert property (@(posedge clock) disable iff (reset)
      digit0_ff <= DIGIT_MAX && digit1_ff <= DIGIT_MAX && digit2_ff <= DIGIT_MAX)
      else $error("entered digit above nine");

   a_pos_in_range: assert property (@(posedge clock) disable iff (reset)
      pos_ff != 2'd3) else $error("digit position out of range");

   a_code_event_resets_pos: assert property (@(posedge clock) disable iff (reset)
      (accept && result.code_event != CODE_EVENT_NONE) |=> pos_ff == POS_FIRST)
      else $error("code closed without clearing position");

endmodule

### test/tb_home_alarm_light_code_controller.sv
module tb_home_alarm_light_code_controller import halcc_pkg::*;;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CLOCK_PERIOD = 10;
   localparam int STALL_LIMIT = 1000;
   localparam int SHOWN_MISMATCHES = 10;

   class panel_status_board;
      bit [TIMER_WIDTH-1:0] hold_ticks;
      bit [TIMER_WIDTH-1:0] gap_ticks;
      bit [DIGIT_WIDTH-1:0] secret [3];
      bit light_lit;
      bit [TIMER_WIDTH-1:0] light_left;
      bit is_armed;
      bit siren;
      bit [3:0] pend;
      bit match_pulse;
      bit [DIGIT_WIDTH-1:0] digits [3];
      bit [1:0] pos;
      bit [TIMER_WIDTH-1:0] gap_left;
      bit pressing;
      rsp_type status_due [$];
      int mismatches;

      function new();
         hold_ticks = LIGHT_HOLD_RESET;
         gap_ticks = PRESS_GAP_RESET;
         secret = '{SECRET_FIRST_RESET, SECRET_SECOND_RESET, SECRET_THIRD_RESET};
         light_lit = 1'b0;
         light_left = '0;
         is_armed = 1'b0;
         siren = 1'b0;
         pend = '0;
         match_pulse = 1'b0;
         digits = '{4'd0, 4'd0, 4'd0};
         pos = POS_FIRST;
         gap_left = '0;
         pressing = 1'b0;
         mismatches = 0;
      endfunction

      function void set_reg(logic [CSR_INDEX_WIDTH-1:0] idx, logic [CSR_DATA_WIDTH-1:0] value);
         case (idx)
            CSR_LIGHT_HOLD: hold_ticks = value;
            CSR_PRESS_GAP: gap_ticks = value;
            CSR_SECRET_FIRST: secret[0] = value[DIGIT_WIDTH-1:0];
            CSR_SECRET_SECOND: secret[1] = value[DIGIT_WIDTH-1:0];
            CSR_SECRET_THIRD: secret[2] = value[DIGIT_WIDTH-1:0];
            default: ;
         endcase
      endfunction

      function void take_tick(bit code_press, bit light_press, bit presence_seen);
         bit turn_on;
         bit hit;
         code_event_type event_code;
         rsp_type want;
         if (code_press) pend[PF_CODE] = 1'b1;
         if (light_press) pend[PF_LIGHT] = 1'b1;
         if (presence_seen) begin
            pend[PF_PRES_L] = 1'b1;
            pend[PF_PRES_A] = 1'b1;
         end

         // light: button wins over presence while lit
         turn_on = 1'b0;
         if (!light_lit) begin
            turn_on = pend[PF_PRES_L] || pend[PF_LIGHT];
         end else if (pend[PF_LIGHT]) begin
            light_lit = 1'b0;
            pend[PF_LIGHT] = 1'b0;
         end else if (pend[PF_PRES_L]) begin
            turn_on = 1'b1;
         end else if (light_left <= 1) begin
            light_left = '0;
            light_lit = 1'b0;
         end else begin
            light_left--;
         end
         if (turn_on) begin
            light_lit = 1'b1;
            pend[PF_PRES_L] = 1'b0;
            pend[PF_LIGHT] = 1'b0;
            light_left = hold_ticks;
         end

         // alarm: presence stays pending while disarmed
         if (!is_armed) begin
            if (match_pulse) begin
               is_armed = 1'b1;
               pend[PF_PRES_A] = 1'b0;
               match_pulse = 1'b0;
            end
         end else if (pend[PF_PRES_A]) begin
            siren = 1'b1;
            pend[PF_PRES_A] = 1'b0;
         end else if (match_pulse) begin
            is_armed = 1'b0;
            siren = 1'b0;
            pend[PF_PRES_A] = 1'b0;
            match_pulse = 1'b0;
         end

         // code entry
         event_code = CODE_EVENT_NONE;
         if (pend[PF_CODE]) begin
            digits[pos] = (digits[pos] >= DIGIT_MAX) ? 4'd0 : digits[pos] + 4'd1;
            pend[PF_CODE] = 1'b0;
            gap_left = gap_ticks;
            match_pulse = 1'b0;
            pressing = 1'b1;
         end else if (pressing) begin
            if (gap_left > 1) begin
               gap_left--;
            end else begin
               gap_left = '0;
               pressing = 1'b0;
               if (pos != POS_THIRD) begin
                  pos++;
                  match_pulse = 1'b0;
               end else begin
                  hit = digits[0] == secret[0] && digits[1] == secret[1] &&
                        digits[2] == secret[2];
                  digits = '{4'd0, 4'd0, 4'd0};
                  pos = POS_FIRST;
                  match_pulse = hit;
                  event_code = hit ? CODE_EVENT_RIGHT : CODE_EVENT_WRONG;
               end
            end
         end

         want.light_on = light_lit;
         want.armed = is_armed;
         want.siren_on = siren;
         want.digit_position = pos;
         want.digit_value = digits[pos];
         want.code_event = event_code;
         status_due.push_back(want);
      endfunction

      function void match_status(logic [RSP_DATA_WIDTH-1:0] word);
         rsp_type got;
         rsp_type want;
         logic [RSP_DATA_WIDTH-$bits(rsp_type)-1:0] fill;
         if (status_due.size() == 0) begin
            mismatches++;
            if (mismatches <= SHOWN_MISMATCHES)
               $display("rsp beat %h with no status outstanding", word);
            return;
         end
         want = status_due.pop_front();
         got = rsp_type'(word[$bits(rsp_type)-1:0]);
         fill = word[RSP_DATA_WIDTH-1:$bits(rsp_type)];
         if (got.light_on !== want.light_on || got.armed !== want.armed ||
             got.siren_on !== want.siren_on || got.digit_position !== want.digit_position ||
             got.digit_value !== want.digit_value || got.code_event !== want.code_event ||
             fill !== '0) begin
            mismatches++;
            if (mismatches <= SHOWN_MISMATCHES)
               $display({"status mismatch: expected light %b armed %b siren %b pos %0d ",
                         "digit %0d event %0d, got light %b armed %b siren %b pos %0d ",
                         "digit %0d event %0d fill %h"},
                        want.light_on, want.armed, want.siren_on, want.digit_position,
                        want.digit_value, want.code_event, got.light_on, got.armed,
                        got.siren_on, got.digit_position, got.digit_value, got.code_event,
                        fill);
         end
      endfunction

      function int outstanding();
         return status_due.size();
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_DATA_WIDTH-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready;
   logic [RSP_DATA_WIDTH-1:0] rsp_tdata;
   logic csr_we = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [CSR_DATA_WIDTH-1:0] csr_wdata = '0;

   panel_status_board board = new();
   bit req_quiet = 1'b0;
   bit rsp_quiet = 1'b0;
   int ticks_sent = 0;
   int stall_cycles = 0;

   // opening beats, {presence, light, code}; hold 0, gap 0, secret 1 2 1
   logic [2:0] opening_ticks [$] = '{
      3'b111, 3'b000,
      3'b001, 3'b001, 3'b000,
      3'b001, 3'b000,
      3'b000, 3'b100, 3'b010, 3'b010, 3'b110, 3'b000,
      3'b001, 3'b001, 3'b000, 3'b001, 3'b000, 3'b001, 3'b000,
      3'b001, 3'b000, 3'b001, 3'b001, 3'b000, 3'b001, 3'b000,
      3'b000
   };

   home_alarm_light_code_controller DUT (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   function automatic int draw_wait(bit quiet);
      return quiet ? 0 : $urandom_range(0, 5);
   endfunction

   task automatic send_tick(input bit code_press, input bit light_press,
                            input bit presence_seen);
      int pause;
      if ($urandom_range(0, 39) == 0) req_quiet = !req_quiet;
      pause = draw_wait(req_quiet);
      if (pause > 0) begin
         req_tvalid <= 1'b0;
         repeat (pause) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= REQ_DATA_WIDTH'({presence_seen, light_press, code_press});
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      board.take_tick(code_press, light_press, presence_seen);
      ticks_sent++;
      @(negedge clock);
   endtask

   task automatic settle();
      req_tvalid <= 1'b0;
      while (board.outstanding() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_WIDTH-1:0] idx,
                            input logic [CSR_DATA_WIDTH-1:0] value);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      board.set_reg(idx, value);
      @(negedge clock);
   endtask

   // presses per digit, spaced under the gap, then enough quiet beats to close it
   task automatic enter_code(input logic [3:0] d0, input logic [3:0] d1,
                             input logic [3:0] d2, input int gap);
      logic [3:0] digit_seq [3];
      int presses;
      int close_ticks;
      digit_seq = '{d0, d1, d2};
      close_ticks = (gap < 1) ? 1 : gap;
      for (int i = 0; i < 3; i++) begin
         presses = int'(digit_seq[i]);
         if (digit_seq[i] == 0 || $urandom_range(0, 3) == 0) presses += 10;
         for (int k = 0; k < presses; k++) begin
            send_tick(1'b1, $urandom_range(0, 7) == 0, $urandom_range(0, 7) == 0);
            if (k < presses - 1)
               repeat ($urandom_range(0, close_ticks - 1))
                  send_tick(1'b0, $urandom_range(0, 7) == 0, $urandom_range(0, 7) == 0);
         end
         repeat (close_ticks)
            send_tick(1'b0, $urandom_range(0, 7) == 0, $urandom_range(0, 7) == 0);
      end
   endtask

   task automatic run_phase(input logic [15:0] hold, input logic [15:0] gap,
                            input logic [3:0] s0, input logic [3:0] s1,
                            input logic [3:0] s2, input int count);
      int stop;
      int pick;
      logic [CSR_DATA_WIDTH-1:0] word;
      settle();
      write_reg(CSR_LIGHT_HOLD, hold);
      write_reg(CSR_PRESS_GAP, gap);
      word = CSR_DATA_WIDTH'($urandom());
      word[3:0] = s0;
      write_reg(CSR_SECRET_FIRST, word);
      word = CSR_DATA_WIDTH'($urandom());
      word[3:0] = s1;
      write_reg(CSR_SECRET_SECOND, word);
      word = CSR_DATA_WIDTH'($urandom());
      word[3:0] = s2;
      write_reg(CSR_SECRET_THIRD, word);
      // unmapped index, must be ignored
      if ($urandom_range(0, 1))
         write_reg(CSR_INDEX_WIDTH'(CSR_SECRET_THIRD + $urandom_range(1, 3)),
                   CSR_DATA_WIDTH'($urandom()));
      csr_we <= 1'b0;
      stop = ticks_sent + count;
      while (ticks_sent < stop) begin
         pick = $urandom_range(0, 9);
         if (gap > 8 || pick >= 8)
            repeat ($urandom_range(1, 12))
               send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                         1'($urandom_range(0, 1)));
         else if (pick < 5)
            enter_code(s0, s1, s2, gap);
         else if (pick < 7)
            enter_code(4'($urandom_range(0, 9)), 4'($urandom_range(0, 9)),
                       4'($urandom_range(0, 9)), gap);
         else
            enter_code(s0, s1, 4'($urandom_range(0, 9)), gap);
      end
   endtask

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stall_cycles = 0;
      end else begin
         stall_cycles++;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("tb_home_alarm_light_code_controller: errors");
            $finish;
         end
      end
   end

   initial begin
      int pause;
      rsp_tready = 1'b0;
      wait (!reset);
      @(negedge clock);
      forever begin
         if ($urandom_range(0, 39) == 0) rsp_quiet = !rsp_quiet;
         pause = draw_wait(rsp_quiet);
         if (pause > 0) begin
            rsp_tready <= 1'b0;
            repeat (pause) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
         board.match_status(rsp_tdata);
         @(negedge clock);
      end
   end

   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      run_phase(16'd0, 16'd0, 4'd1, 4'd2, 4'd1, 0);
      foreach (opening_ticks[i])
         send_tick(opening_ticks[i][0], opening_ticks[i][1], opening_ticks[i][2]);

      run_phase(16'd1, 16'd1, 4'($urandom_range(0, 9)), 4'($urandom_range(0, 9)),
                4'($urandom_range(0, 9)), 250);
      run_phase(16'hFFFF, 16'd2, 4'($urandom_range(0, 9)), 4'($urandom_range(0, 9)),
                4'($urandom_range(0, 9)), 250);
      run_phase(LIGHT_HOLD_RESET, PRESS_GAP_RESET, SECRET_FIRST_RESET, SECRET_SECOND_RESET,
                SECRET_THIRD_RESET, 200);
      run_phase(16'($urandom_range(2, 40)), 16'd3, 4'($urandom_range(0, 9)),
                4'($urandom_range(10, 15)), 4'($urandom_range(0, 9)), 150);
      run_phase(16'd0, 16'd0, 4'd0, 4'd0, 4'd0, 200);
      run_phase(16'($urandom_range(2, 40)), 16'hFFFF, 4'($urandom_range(0, 9)),
                4'($urandom_range(0, 9)), 4'($urandom_range(0, 9)), 40);
      run_phase(16'($urandom_range(2, 60)), 16'($urandom_range(1, 4)),
                4'($urandom_range(0, 9)), 4'($urandom_range(0, 9)),
                4'($urandom_range(0, 9)), 300);
      run_phase(16'd3, 16'd1, DIGIT_MAX, DIGIT_MAX, DIGIT_MAX, 250);

      settle();
      board.mismatches += board.outstanding();
      if (board.mismatches == 0)
         $display("tb_home_alarm_light_code_controller: clean");
      else
         $display("tb_home_alarm_light_code_controller: errors");
      $finish;
   end

endmodule
